@@ src/vumbr_pkg.sv @@
// VU meter bar renderer: shared widths, colour constants, codes and types.
// Also holds the elaboration-time level-to-row table builder.
// No dependencies.
`default_nettype none

package vumbr_pkg;

	localparam int ROW_W     = 7;
	localparam int LVL_W     = 9;
	localparam int COL_W     = 6;
	localparam int RGB_W     = 24;
	localparam int CNT_W     = 4;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int GEO_W     = 8;
	localparam int LUT_DEPTH = 64;
	localparam int LUT_IDX_W = 6;

	localparam int DEF_CHANNELS     = 8;
	localparam int DEF_DISPLAY_ROWS = 88;
	localparam int DEF_DISPLAY_COLS = 64;

	localparam logic signed [LVL_W-1:0] LVL_MAX_ACTIVE = 9'sd3;
	localparam logic signed [LVL_W:0]   LVL_OFFSET     = 10'sd60;

	localparam logic [ROW_W-1:0] HEADROOM_RST  = 7'd58;
	localparam logic [ROW_W-1:0] OVERDRIVE_RST = 7'd83;
	localparam logic [ROW_W-1:0] DECAY_RST     = 7'd1;

	localparam logic [RGB_W-1:0] RGB_GREEN   = 24'h00FF00;
	localparam logic [RGB_W-1:0] RGB_DGREEN  = 24'h00BF00;
	localparam logic [RGB_W-1:0] RGB_YELLOW  = 24'hA0C000;
	localparam logic [RGB_W-1:0] RGB_DYELLOW = 24'h789000;
	localparam logic [RGB_W-1:0] RGB_RED     = 24'hFF0000;
	localparam logic [RGB_W-1:0] RGB_DRED    = 24'hBF0000;
	localparam logic [RGB_W-1:0] RGB_BLACK   = 24'h000000;

	typedef enum logic [1:0] {
		CLR_GREEN  = 2'd0,
		CLR_YELLOW = 2'd1,
		CLR_RED    = 2'd2
	} pk_colour_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_HEADROOM  = 2'd0,
		CFG_OVERDRIVE = 2'd1,
		CFG_DECAY     = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic             active;
		logic [ROW_W-1:0] bar;
		logic [ROW_W-1:0] peak;
		pk_colour_t       colour;
	} lane_res_t;

	typedef struct packed {
		logic [ROW_W-1:0] bar;
		logic [ROW_W-1:0] peak;
		pk_colour_t       colour;
	} slot_t;

	// row = floor(((rows-1)*100*u + 3087) / 6300), u = level + 60, clamped
	function automatic logic [LUT_DEPTH*ROW_W-1:0] build_row_lut(input int rows);
		logic [LUT_DEPTH*ROW_W-1:0] t;
		int u;
		int num;
		int r;
		t = '0;
		for (u = 0; u < LUT_DEPTH; u++) begin
			num = (rows - 1) * 100 * u + 3087;
			r = num / 6300;
			if (r > rows - 1)
				r = rows - 1;
			t[u*ROW_W +: ROW_W] = r[ROW_W-1:0];
		end
		return t;
	endfunction

endpackage

`default_nettype wire

@@ src/vu_meter_bar_renderer.sv @@
// VU meter bar renderer, top level: config registers, lanes, merge, pixel path.
// Depends on vumbr_pkg, vumbr_lane, vumbr_merge, vumbr_pixel.
//
// Takes one transaction per clock while the output is not stalled, updates and
// pixel reads alike, and returns one result per transaction through three
// register stages: an input stage
// (one lane per channel maps the level and updates its held peak), a slot stage
// (active lanes are packed into slots while the pixel's slot and offset are
// found), and the output register. A stalled output holds the whole pipeline.
// Pixel reads see every earlier update. No clearing pass after reset.
`default_nettype none

module vu_meter_bar_renderer #(
	parameter int CHANNELS     = vumbr_pkg::DEF_CHANNELS,
	parameter int DISPLAY_ROWS = vumbr_pkg::DEF_DISPLAY_ROWS,
	parameter int DISPLAY_COLS = vumbr_pkg::DEF_DISPLAY_COLS
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               func,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch0,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch1,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch2,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch3,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch4,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch5,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch6,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0] level_ch7,
	input  wire logic [vumbr_pkg::ROW_W-1:0]        pixel_row,
	input  wire logic [vumbr_pkg::COL_W-1:0]        pixel_col,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [vumbr_pkg::RGB_W-1:0]             pixel_rgb,
	output logic [vumbr_pkg::CNT_W-1:0]             active_channels,
	input  wire logic                               cfg_we,
	input  wire logic [vumbr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vumbr_pkg::CFG_W-1:0]        cfg_data
);
	import vumbr_pkg::*;

	localparam int SLOT_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int MAX_CH     = 8;

	logic [ROW_W-1:0] headroom_q;
	logic [ROW_W-1:0] overdrive_q;
	logic [ROW_W-1:0] decay_q;

	logic                    advance;
	logic                    in_accept;
	logic                    lane_update;
	logic signed [LVL_W-1:0] levels [MAX_CH];
	lane_res_t               lane_res [CHANNELS];

	logic             valid_s1;
	logic             func_s1;
	logic [ROW_W-1:0] row_s1;
	logic [COL_W-1:0] col_s1;
	logic             valid_s2;
	logic             func_s2;

	logic                  merge_wr;
	logic [CNT_W-1:0]      count_q;
	logic [SLOT_IDX_W-1:0] slot_idx_s2;
	slot_t                 rd_slot;
	logic [RGB_W-1:0]      pix_rgb;

	logic             out_valid_q;
	logic [RGB_W-1:0] rgb_q;
	logic [CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			headroom_q <= HEADROOM_RST;
			overdrive_q <= OVERDRIVE_RST;
			decay_q <= DECAY_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_HEADROOM:  headroom_q <= cfg_data;
				CFG_OVERDRIVE: overdrive_q <= cfg_data;
				CFG_DECAY:     decay_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign advance = !out_valid_q || !out_stall;
	assign in_stall = !advance;
	assign in_accept = in_valid && advance;
	assign lane_update = in_accept && !func;

	assign levels[0] = level_ch0;
	assign levels[1] = level_ch1;
	assign levels[2] = level_ch2;
	assign levels[3] = level_ch3;
	assign levels[4] = level_ch4;
	assign levels[5] = level_ch5;
	assign levels[6] = level_ch6;
	assign levels[7] = level_ch7;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		vumbr_lane #(
			.DISPLAY_ROWS(DISPLAY_ROWS)
		) u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.update(lane_update),
			.level(levels[c]),
			.headroom(headroom_q),
			.overdrive(overdrive_q),
			.decay(decay_q),
			.res_s1(lane_res[c])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1 <= func;
			row_s1 <= pixel_row;
			col_s1 <= pixel_col;
			func_s2 <= func_s1;
			rgb_q <= func_s2 ? pix_rgb : RGB_BLACK;
			cnt_q <= count_q;
		end
	end

	assign merge_wr = advance && valid_s1 && !func_s1;

	vumbr_merge #(
		.CHANNELS(CHANNELS)
	) u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.wr(merge_wr),
		.lane_res(lane_res),
		.rd_idx(slot_idx_s2),
		.rd_slot(rd_slot),
		.count_q(count_q)
	);

	vumbr_pixel #(
		.CHANNELS(CHANNELS),
		.DISPLAY_ROWS(DISPLAY_ROWS),
		.DISPLAY_COLS(DISPLAY_COLS)
	) u_pixel (
		.clk(clk),
		.en(advance),
		.row(row_s1),
		.col(col_s1),
		.count(count_q),
		.headroom(headroom_q),
		.overdrive(overdrive_q),
		.slot_idx_s2(slot_idx_s2),
		.rd_slot(rd_slot),
		.rgb(pix_rgb)
	);

	assign out_valid = out_valid_q;
	assign pixel_rgb = rgb_q;
	assign active_channels = cnt_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CHANNELS))
		else $error("active slot count exceeds channel count");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !advance) |=> valid_s2)
		else $error("transaction dropped from slot stage while stalled");

	a_accept_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> valid_s1)
		else $error("accepted transaction missing from input stage");

	a_update_black: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && valid_s2 && !func_s2) |=> (pixel_rgb == RGB_BLACK))
		else $error("update transaction returned a nonzero colour");

endmodule

`default_nettype wire

@@ src/vumbr_lane.sv @@
// VU meter per-channel lane: level to row, peak decay and peak colour.
// Holds the channel's held peak state. Depends on vumbr_pkg.
`default_nettype none

module vumbr_lane #(
	parameter int DISPLAY_ROWS = vumbr_pkg::DEF_DISPLAY_ROWS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                update,
	input  wire logic signed [vumbr_pkg::LVL_W-1:0]  level,
	input  wire logic [vumbr_pkg::ROW_W-1:0]         headroom,
	input  wire logic [vumbr_pkg::ROW_W-1:0]         overdrive,
	input  wire logic [vumbr_pkg::ROW_W-1:0]         decay,
	output vumbr_pkg::lane_res_t                     res_s1
);
	import vumbr_pkg::*;

	localparam logic [LUT_DEPTH*ROW_W-1:0] ROW_LUT = build_row_lut(DISPLAY_ROWS);

	logic [ROW_W-1:0]     peak_q;
	pk_colour_t           colour_q;
	logic                 active;
	logic signed [LVL_W:0] lvl_sum;
	logic [LUT_IDX_W-1:0] lut_idx;
	logic [ROW_W-1:0]     row;
	logic [ROW_W-1:0]     dec;
	logic [ROW_W-1:0]     bar;
	logic                 new_pk;
	logic [ROW_W-1:0]     peak_nxt;
	pk_colour_t           colour_nxt;

	always_comb begin
		active = (level <= LVL_MAX_ACTIVE);
		lvl_sum = {level[LVL_W-1], level} + LVL_OFFSET;
		lut_idx = lvl_sum[LVL_W] ? '0 : lvl_sum[LUT_IDX_W-1:0];
		row = ROW_LUT[lut_idx*ROW_W +: ROW_W];
		dec = (peak_q > decay) ? peak_q - decay : '0;
		new_pk = (row > dec);
		bar = (row == '0) ? ROW_W'(1) : row;
		peak_nxt = dec;
		colour_nxt = colour_q;
		if (!active) begin
			peak_nxt = '0;
		end else if (new_pk) begin
			peak_nxt = row;
			if (row < headroom)
				colour_nxt = CLR_GREEN;
			else if (row < overdrive)
				colour_nxt = CLR_YELLOW;
			else
				colour_nxt = CLR_RED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
			colour_q <= CLR_GREEN;
		end else if (update) begin
			peak_q <= peak_nxt;
			colour_q <= colour_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (update) begin
			res_s1.active <= active;
			res_s1.bar <= bar;
			res_s1.peak <= peak_nxt;
			res_s1.colour <= colour_nxt;
		end
	end

endmodule

`default_nettype wire

@@ src/vumbr_merge.sv @@
// VU meter merge stage: packs active lanes into display slots, keeps the count.
// Provides one slot read port for the pixel path. Depends on vumbr_pkg.
`default_nettype none

module vumbr_merge #(
	parameter int CHANNELS = vumbr_pkg::DEF_CHANNELS
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        wr,
	input  wire vumbr_pkg::lane_res_t        lane_res [CHANNELS],
	input  wire logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] rd_idx,
	output vumbr_pkg::slot_t                 rd_slot,
	output logic [vumbr_pkg::CNT_W-1:0]      count_q
);
	import vumbr_pkg::*;

	localparam int SLOT_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	slot_t            slot_q   [CHANNELS];
	slot_t            slot_nxt [CHANNELS];
	logic [CNT_W-1:0] pos;

	always_comb begin
		pos = '0;
		for (int j = 0; j < CHANNELS; j++)
			slot_nxt[j] = slot_q[j];
		for (int i = 0; i < CHANNELS; i++) begin
			if (lane_res[i].active) begin
				slot_nxt[pos[SLOT_IDX_W-1:0]].bar = lane_res[i].bar;
				slot_nxt[pos[SLOT_IDX_W-1:0]].peak = lane_res[i].peak;
				slot_nxt[pos[SLOT_IDX_W-1:0]].colour = lane_res[i].colour;
				pos = pos + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr) begin
			for (int j = 0; j < CHANNELS; j++)
				slot_q[j] <= slot_nxt[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (wr)
			count_q <= pos;
	end

	assign rd_slot = slot_q[rd_idx];

endmodule

`default_nettype wire

@@ src/vumbr_pixel.sv @@
// VU meter pixel path: slot geometry stage (registered) and colour selection.
// Reads one slot through the merge stage's read port. Depends on vumbr_pkg.
`default_nettype none

module vumbr_pixel #(
	parameter int CHANNELS     = vumbr_pkg::DEF_CHANNELS,
	parameter int DISPLAY_ROWS = vumbr_pkg::DEF_DISPLAY_ROWS,
	parameter int DISPLAY_COLS = vumbr_pkg::DEF_DISPLAY_COLS
) (
	input  wire logic                        clk,
	input  wire logic                        en,
	input  wire logic [vumbr_pkg::ROW_W-1:0] row,
	input  wire logic [vumbr_pkg::COL_W-1:0] col,
	input  wire logic [vumbr_pkg::CNT_W-1:0] count,
	input  wire logic [vumbr_pkg::ROW_W-1:0] headroom,
	input  wire logic [vumbr_pkg::ROW_W-1:0] overdrive,
	output logic [((CHANNELS > 1) ? $clog2(CHANNELS) : 1)-1:0] slot_idx_s2,
	input  wire vumbr_pkg::slot_t            rd_slot,
	output logic [vumbr_pkg::RGB_W-1:0]      rgb
);
	import vumbr_pkg::*;

	localparam int SLOT_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int NI_W       = $clog2(CHANNELS + 1);
	localparam int PROD_W     = GEO_W + 3;

	logic [GEO_W-1:0]      w_by_n [CHANNELS+1];
	logic [GEO_W-1:0]      w;
	logic [PROD_W-1:0]     col_x;
	logic [PROD_W-1:0]     bnd;
	logic [PROD_W-1:0]     base;
	logic [SLOT_IDX_W-1:0] sl;
	logic                  full;
	logic                  black;
	logic [GEO_W-1:0]      x;
	logic [3:0]            pm;
	logic [ROW_W-1:0]      h;

	logic [GEO_W-1:0]      x_s2;
	logic [GEO_W-1:0]      w_s2;
	logic [3:0]            pm_s2;
	logic [ROW_W-1:0]      h_s2;
	logic                  dark_s2;
	logic                  black_s2;

	logic [GEO_W:0]        x_pm;
	logic [GEO_W:0]        x_bm;
	logic                  peak_ok;
	logic                  bar_ok;

	assign w_by_n[0] = '0;
	for (genvar g = 1; g <= CHANNELS; g++) begin : g_width
		localparam int W = DISPLAY_COLS / g;
		assign w_by_n[g] = GEO_W'(W);
	end

	always_comb begin
		w = w_by_n[count[NI_W-1:0]];
		col_x = PROD_W'(col);
		black = (count == '0) || (count > CNT_W'(CHANNELS))
			|| ({1'b0, row} >= GEO_W'(DISPLAY_ROWS))
			|| (col_x >= PROD_W'(DISPLAY_COLS));
		sl = '0;
		for (int j = 1; j < CHANNELS; j++) begin
			bnd = PROD_W'(j) * PROD_W'(w);
			if ((CNT_W'(j) < count) && (col_x >= bnd))
				sl = sl + SLOT_IDX_W'(1);
		end
		full = (col_x >= PROD_W'(count) * PROD_W'(w));
		base = PROD_W'(sl) * PROD_W'(w);
		x = full ? '0 : GEO_W'(col_x - base);
		pm = 4'(CHANNELS + 1) - count;
		h = ROW_W'(DISPLAY_ROWS - 1) - row;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			slot_idx_s2 <= sl;
			x_s2 <= x;
			w_s2 <= w;
			pm_s2 <= pm;
			h_s2 <= h;
			dark_s2 <= (row[1:0] == 2'b11);
			black_s2 <= black;
		end
	end

	always_comb begin
		x_pm = {1'b0, x_s2} + (GEO_W + 1)'(pm_s2);
		x_bm = x_pm + (GEO_W + 1)'(1);
		peak_ok = (x_s2 >= GEO_W'(pm_s2)) && (x_pm < {1'b0, w_s2});
		bar_ok = (x_s2 > GEO_W'(pm_s2)) && (x_bm < {1'b0, w_s2});
		rgb = RGB_BLACK;
		if (black_s2) begin
			rgb = RGB_BLACK;
		end else if (rd_slot.peak == h_s2) begin
			if (peak_ok) begin
				case (rd_slot.colour)
					CLR_GREEN:  rgb = RGB_GREEN;
					CLR_YELLOW: rgb = RGB_YELLOW;
					default:    rgb = RGB_RED;
				endcase
			end
		end else if ((rd_slot.bar >= h_s2) && bar_ok) begin
			if (h_s2 < headroom)
				rgb = dark_s2 ? RGB_DGREEN : RGB_GREEN;
			else if (h_s2 < overdrive)
				rgb = dark_s2 ? RGB_DYELLOW : RGB_YELLOW;
			else
				rgb = dark_s2 ? RGB_DRED : RGB_RED;
		end
	end

endmodule

`default_nettype wire

@@ bench/vu_meter_bar_renderer_test.sv @@
// Self-checking testbench for vu_meter_bar_renderer: directed table, then random phases.
// Holds its own model of peaks, slots and pixel colours; depends on vumbr_pkg and the RTL.
`default_nettype none

module vu_meter_bar_renderer_test;
	import vumbr_pkg::*;

	localparam logic OP_UPDATE = 1'b0;
	localparam logic OP_PIXEL  = 1'b1;

	localparam int ROWS  = DEF_DISPLAY_ROWS;
	localparam int COLS  = DEF_DISPLAY_COLS;
	localparam int CHANS = DEF_CHANNELS;

	localparam int PHASES       = 11;
	localparam int PHASE_ITEMS  = 150;
	localparam int HOLD_AT      = 680;
	localparam int HOLD_CYCLES  = 120;
	localparam int DRAIN_CYCLES = 10;
	localparam int TIMEOUT      = 12_000_000;

	typedef struct packed {
		logic               op;
		logic [0:7][8:0]    lvl;
		logic [ROW_W-1:0]   row;
		logic [COL_W-1:0]   col;
		logic               fixed_exp;
		logic [RGB_W-1:0]   t_rgb;
		logic [CNT_W-1:0]   t_count;
	} vu_stim_t;

	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic [CNT_W-1:0] count;
	} vu_result_t;

	localparam int DIRECTED_ROWS = 25;
	localparam vu_stim_t DIRECTED [DIRECTED_ROWS] = '{
		'{OP_PIXEL,  {8{9'h000}}, 7'd0,   6'd0,  1'b1, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd87,  6'd63, 1'b1, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {8{9'd255}}, 7'd0,   6'd0,  1'b1, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {8{9'h100}}, 7'd0,   6'd0,  1'b1, RGB_BLACK, 4'd8},
		'{OP_PIXEL,  {8{9'h000}}, 7'd87,  6'd2,  1'b0, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {8{9'd3}},   7'd0,   6'd0,  1'b1, RGB_BLACK, 4'd8},
		'{OP_PIXEL,  {8{9'h000}}, 7'd0,   6'd1,  1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd3,   6'd2,  1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd2,   6'd0,  1'b0, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {9'd4, -9'sd60, -9'sd18, 9'd0, 9'd3, -9'sd61, -9'sd128, 9'd255},
			7'd0, 6'd0, 1'b1, RGB_BLACK, 4'd6},
		'{OP_PIXEL,  {8{9'h000}}, 7'd95,  6'd5,  1'b1, RGB_BLACK, 4'd6},
		'{OP_PIXEL,  {8{9'h000}}, 7'd127, 6'd5,  1'b1, RGB_BLACK, 4'd6},
		'{OP_PIXEL,  {8{9'h000}}, 7'd40,  6'd63, 1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd60,  6'd12, 1'b0, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {8{-9'sd40}}, 7'd0,  6'd0,  1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd30,  6'd10, 1'b0, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {8{9'd4}},   7'd0,   6'd0,  1'b1, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd50,  6'd20, 1'b1, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {{7{9'd255}}, -9'sd30}, 7'd0, 6'd0, 1'b1, RGB_BLACK, 4'd1},
		'{OP_PIXEL,  {8{9'h000}}, 7'd70,  6'd8,  1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd70,  6'd30, 1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd46,  6'd7,  1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd46,  6'd8,  1'b0, RGB_BLACK, 4'd0},
		'{OP_UPDATE, {9'h155, 9'h0AA, 9'h1FF, 9'h000, 9'h155, 9'h0AA, 9'h1FF, 9'h000},
			7'd0, 6'd0, 1'b0, RGB_BLACK, 4'd0},
		'{OP_PIXEL,  {8{9'h000}}, 7'd64,  6'd42, 1'b0, RGB_BLACK, 4'd0}
	};

	// fixed register settings for the first phases, later phases are random
	localparam int FIXED_PHASES = 6;
	localparam logic [CFG_W-1:0] PH_HEAD  [FIXED_PHASES] = '{7'd58, 7'd0, 7'd87, 7'd127, 7'd20, 7'd60};
	localparam logic [CFG_W-1:0] PH_OVER  [FIXED_PHASES] = '{7'd83, 7'd0, 7'd87, 7'd127, 7'd60, 7'd20};
	localparam logic [CFG_W-1:0] PH_DECAY [FIXED_PHASES] = '{7'd1,  7'd0, 7'd87, 7'd127, 7'd3,  7'd10};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic func;
	logic signed [LVL_W-1:0] level_ch0, level_ch1, level_ch2, level_ch3;
	logic signed [LVL_W-1:0] level_ch4, level_ch5, level_ch6, level_ch7;
	logic [ROW_W-1:0] pixel_row;
	logic [COL_W-1:0] pixel_col;
	logic out_valid;
	logic out_stall;
	logic [RGB_W-1:0] pixel_rgb;
	logic [CNT_W-1:0] active_channels;
	logic cfg_we;
	cfg_idx_t cfg_index;
	logic [CFG_W-1:0] cfg_data;

	// model state
	logic [CFG_W-1:0] headroom, overdrive, decay;
	logic [ROW_W-1:0] peak_hold [CHANS];
	pk_colour_t       peak_clr  [CHANS];
	logic [ROW_W-1:0] slot_bar  [CHANS];
	logic [ROW_W-1:0] slot_peak [CHANS];
	pk_colour_t       slot_clr  [CHANS];
	int               lit_count;

	vu_result_t pending_results [$];
	int mismatches;
	int accepted_items;
	logic calm;
	logic hold_done;

	vu_meter_bar_renderer u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.func            (func),
		.level_ch0       (level_ch0),
		.level_ch1       (level_ch1),
		.level_ch2       (level_ch2),
		.level_ch3       (level_ch3),
		.level_ch4       (level_ch4),
		.level_ch5       (level_ch5),
		.level_ch6       (level_ch6),
		.level_ch7       (level_ch7),
		.pixel_row       (pixel_row),
		.pixel_col       (pixel_col),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.pixel_rgb       (pixel_rgb),
		.active_channels (active_channels),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	function automatic logic [ROW_W-1:0] level_row(input logic signed [LVL_W-1:0] lv);
		int num;
		num = (ROWS - 1) * 100 * (int'(lv) + 60) + 3087;
		if (num < 0)
			return '0;
		num = num / 6300;
		if (num > ROWS - 1)
			num = ROWS - 1;
		return num[ROW_W-1:0];
	endfunction

	function automatic logic [RGB_W-1:0] mark_rgb(input pk_colour_t c);
		case (c)
			CLR_GREEN:  return RGB_GREEN;
			CLR_YELLOW: return RGB_YELLOW;
			default:    return RGB_RED;
		endcase
	endfunction

	function automatic void apply_update(input vu_stim_t it);
		int n;
		logic [ROW_W-1:0] r;
		n = 0;
		for (int i = 0; i < CHANS; i++) begin
			if ($signed(it.lvl[i]) > 9'sd3) begin
				peak_hold[i] = '0;
				continue;
			end
			if (peak_hold[i] > decay)
				peak_hold[i] = peak_hold[i] - decay;
			else
				peak_hold[i] = '0;
			r = level_row($signed(it.lvl[i]));
			if (r > peak_hold[i]) begin
				peak_hold[i] = r;
				if (r < headroom)
					peak_clr[i] = CLR_GREEN;
				else if (r < overdrive)
					peak_clr[i] = CLR_YELLOW;
				else
					peak_clr[i] = CLR_RED;
			end
			if (r < 1)
				r = 7'd1;
			slot_bar[n]  = r;
			slot_peak[n] = peak_hold[i];
			slot_clr[n]  = peak_clr[i];
			n++;
		end
		lit_count = n;
	endfunction

	function automatic logic [RGB_W-1:0] predict_pixel(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col);
		int n, w, s, x, h, pm, bm;
		logic dark;
		n = lit_count;
		if (n == 0 || row >= ROWS || col >= COLS)
			return RGB_BLACK;
		w = COLS / n;
		s = int'(col) / w;
		x = int'(col) % w;
		if (s >= n) begin
			s = n - 1;
			x = 0;
		end
		h  = (ROWS - 1) - int'(row);
		pm = (CHANS + 1) - n;
		bm = (CHANS + 2) - n;
		if (int'(slot_peak[s]) == h) begin
			if (x >= pm && x < w - pm)
				return mark_rgb(slot_clr[s]);
			return RGB_BLACK;
		end
		if (int'(slot_bar[s]) >= h && x >= bm && x < w - bm) begin
			dark = (row[1:0] == 2'd3);
			if (h < int'(headroom))
				return dark ? RGB_DGREEN : RGB_GREEN;
			if (h < int'(overdrive))
				return dark ? RGB_DYELLOW : RGB_YELLOW;
			return dark ? RGB_DRED : RGB_RED;
		end
		return RGB_BLACK;
	endfunction

	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic note_mismatch(input string what, input logic [RGB_W-1:0] want,
			input logic [RGB_W-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, got);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			CFG_HEADROOM:  headroom  = val;
			CFG_OVERDRIVE: overdrive = val;
			default:       decay     = val;
		endcase
	endtask

	task automatic offer_item(input vu_stim_t it, input int gap);
		vu_result_t want;
		@(negedge clk);
		in_valid  = 1'b1;
		func      = it.op;
		level_ch0 = it.lvl[0];
		level_ch1 = it.lvl[1];
		level_ch2 = it.lvl[2];
		level_ch3 = it.lvl[3];
		level_ch4 = it.lvl[4];
		level_ch5 = it.lvl[5];
		level_ch6 = it.lvl[6];
		level_ch7 = it.lvl[7];
		pixel_row = it.row;
		pixel_col = it.col;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		accepted_items++;
		if (it.op == OP_UPDATE) begin
			apply_update(it);
			want.rgb = RGB_BLACK;
		end else begin
			want.rgb = predict_pixel(it.row, it.col);
		end
		want.count = lit_count[CNT_W-1:0];
		if (it.fixed_exp) begin
			want.rgb   = it.t_rgb;
			want.count = it.t_count;
		end
		pending_results.push_back(want);
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1)
				@(negedge clk);
		end
	endtask

	// result checker
	always @(posedge clk) begin
		vu_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_mismatch("unexpected pixel_rgb", '0, pixel_rgb);
			end else begin
				want = pending_results.pop_front();
				if (pixel_rgb !== want.rgb)
					note_mismatch("pixel_rgb", want.rgb, pixel_rgb);
				if (active_channels !== want.count)
					note_mismatch("active_channels", 24'(want.count), 24'(active_channels));
			end
		end
	end

	// receiver back-pressure, with one long hold while the sender keeps going
	initial begin
		int r, len;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (!hold_done && accepted_items >= HOLD_AT) begin
				out_stall = 1'b1;
				repeat (HOLD_CYCLES)
					@(negedge clk);
				hold_done = 1'b1;
				out_stall = 1'b0;
			end else if (calm) begin
				out_stall = 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_stall = 1'b0;
					len = $urandom_range(1, 6);
				end else begin
					out_stall = 1'b1;
					if (r < 88)
						len = $urandom_range(1, 3);
					else if (r < 97)
						len = $urandom_range(4, 10);
					else
						len = $urandom_range(20, 40);
				end
				repeat (len - 1)
					@(negedge clk);
			end
		end
	end

	initial begin
		#(TIMEOUT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		vu_stim_t it;
		int r, q, s, w, tmp, solo, gap;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		func      = OP_UPDATE;
		level_ch0 = '0;
		level_ch1 = '0;
		level_ch2 = '0;
		level_ch3 = '0;
		level_ch4 = '0;
		level_ch5 = '0;
		level_ch6 = '0;
		level_ch7 = '0;
		pixel_row = '0;
		pixel_col = '0;
		cfg_we    = 1'b0;
		cfg_index = CFG_HEADROOM;
		cfg_data  = '0;
		calm      = 1'b0;
		hold_done = 1'b0;
		mismatches     = 0;
		accepted_items = 0;
		headroom  = HEADROOM_RST;
		overdrive = OVERDRIVE_RST;
		decay     = DECAY_RST;
		lit_count = 0;
		for (int i = 0; i < CHANS; i++) begin
			peak_hold[i] = '0;
			peak_clr[i]  = CLR_GREEN;
			slot_bar[i]  = '0;
			slot_peak[i] = '0;
			slot_clr[i]  = CLR_GREEN;
		end
		repeat (4)
			@(negedge clk);
		arst_n = 1'b1;

		for (int k = 0; k < DIRECTED_ROWS; k++) begin
			gap = pick_gap();
			offer_item(DIRECTED[k], (k == DIRECTED_ROWS - 1 && gap == 0) ? 1 : gap);
		end

		for (int p = 0; p < PHASES; p++) begin
			// registers change only with the pipeline drained
			while (pending_results.size() != 0)
				@(posedge clk);
			repeat (4)
				@(posedge clk);
			if (p < FIXED_PHASES) begin
				write_reg(CFG_HEADROOM, PH_HEAD[p]);
				write_reg(CFG_OVERDRIVE, PH_OVER[p]);
				write_reg(CFG_DECAY, PH_DECAY[p]);
			end else begin
				write_reg(CFG_HEADROOM, 7'($urandom_range(0, 127)));
				write_reg(CFG_OVERDRIVE, 7'($urandom_range(0, 127)));
				write_reg(CFG_DECAY, (p == PHASES - 1) ? 7'($urandom_range(0, 127))
					: 7'($urandom_range(0, 6)));
			end
			calm = (p == 1);

			for (int k = 0; k < PHASE_ITEMS; k++) begin
				it = '0;
				for (int i = 0; i < CHANS; i++) begin
					tmp = $urandom;
					it.lvl[i] = tmp[8:0];
				end
				it.row = 7'($urandom_range(0, 127));
				it.col = 6'($urandom_range(0, 63));
				it.op  = ($urandom_range(0, 5) == 0) ? OP_UPDATE : OP_PIXEL;
				if (it.op == OP_UPDATE) begin
					r    = $urandom_range(0, 99);
					solo = $urandom_range(0, CHANS - 1);
					for (int i = 0; i < CHANS; i++) begin
						q = $urandom_range(0, 99);
						if (r < 5 || (r < 15 && i != solo) || (r >= 15 && q < 12))
							tmp = $urandom_range(4, 255);
						else if (r >= 15 && q < 20)
							tmp = $urandom_range(0, 511);
						else
							tmp = int'($urandom_range(0, 69)) - 66;
						it.lvl[i] = tmp[8:0];
					end
				end else begin
					q = $urandom_range(0, 99);
					if (q < 30 && lit_count > 0) begin
						w = COLS / lit_count;
						s = $urandom_range(0, lit_count - 1);
						it.row = 7'((ROWS - 1) - int'(slot_peak[s]));
						it.col = 6'(s * w + int'($urandom_range(0, w - 1)));
					end else if (q < 40) begin
						it.row = 7'($urandom_range(ROWS, 127));
					end else begin
						it.row = 7'($urandom_range(0, ROWS - 1));
					end
				end
				gap = pick_gap();
				offer_item(it, (k == PHASE_ITEMS - 1 && gap == 0) ? 1 : gap);
			end
		end
		calm = 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

`default_nettype wire
